// ===== rtl/dlsr_pkg.sv =====
package dlsr_pkg;

  // Widths fixed by the command fields.
  localparam int COORD_W = 8;
  localparam int RAD_W   = 6;
  localparam int POS_W   = 6;
  localparam int ROW_W   = 6;   // canvas rows never exceed 64
  localparam int EXT_W   = 11;  // signed width for coordinate arithmetic
  localparam int SQ_W    = 12;  // radius squared

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEL    = 2'd1,
    OP_RENDER = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_RECT = 2'd0,
    KIND_LINE = 2'd1,
    KIND_TRI  = 2'd2,
    KIND_CIRC = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  // One display list entry as held in the shape memory.
  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic [RAD_W-1:0]          radius;
  } shape_t;

  // Request from the sequencer to the coverage unit.
  typedef struct packed {
    logic             start;
    logic [ROW_W-1:0] row;
  } cover_req_t;

endpackage

// ===== rtl/dlsr_cmd_if.sv =====
interface dlsr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] shape_kind;
  logic signed [7:0] point_a_x;
  logic signed [7:0] point_a_y;
  logic signed [7:0] point_b_x;
  logic signed [7:0] point_b_y;
  logic [5:0] circle_radius;
  logic [5:0] position;

  modport source (
    output valid, opcode, shape_kind, point_a_x, point_a_y, point_b_x, point_b_y,
    output circle_radius, position,
    input  ready
  );
  modport sink (
    input  valid, opcode, shape_kind, point_a_x, point_a_y, point_b_x, point_b_y,
    input  circle_radius, position,
    output ready
  );
endinterface

// ===== rtl/dlsr_res_if.sv =====
interface dlsr_res_if #(parameter int PIX_W = 50);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [4:0]       row_number;
  logic [PIX_W-1:0] row_pixels;
  logic [4:0]       shapes_held;
  logic             last;

  modport source (
    output valid, status, row_number, row_pixels, shapes_held, last,
    input  ready
  );
  modport sink (
    input  valid, status, row_number, row_pixels, shapes_held, last,
    output ready
  );
endinterface

// ===== rtl/dlsr_cover.sv =====
module dlsr_cover #(
  parameter int CANVAS_WIDTH = 50
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dlsr_pkg::cover_req_t     req_i,
  input  dlsr_pkg::shape_t         shape_i,
  output logic                     done_o,
  output logic [CANVAS_WIDTH-1:0]  mask_o
);

  localparam int EW = dlsr_pkg::EXT_W;
  localparam int QW = dlsr_pkg::SQ_W;
  localparam int RW = dlsr_pkg::RAD_W;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_EVAL = 5'b00010,
    C_SQRT = 5'b00100,
    C_FIN  = 5'b01000,
    C_DONE = 5'b10000
  } cst_e;

  // Columns lo..hi of the row, clipped to the canvas.
  function automatic logic [CANVAS_WIDTH-1:0] span(logic signed [EW-1:0] lo,
                                                   logic signed [EW-1:0] hi);
    logic [CANVAS_WIDTH-1:0] m;
    logic signed [EW-1:0]    cc;
    m = '0;
    for (int c = 0; c < CANVAS_WIDTH; c++) begin
      cc = EW'(c);
      m[c] = (cc >= lo) && (cc <= hi);
    end
    return m;
  endfunction

  cst_e                    cst_q, cst_d;
  dlsr_pkg::shape_t        sh_q;
  logic signed [EW-1:0]    y_q;
  logic [QW-1:0]           rest_q, rest_d;
  logic [RW-1:0]           root_q, root_d;
  logic [2:0]              bit_q, bit_d;
  logic [CANVAS_WIDTH-1:0] mask_q, mask_d;

  logic signed [EW-1:0] ax, ay, bx, by, xlo, xhi, ylo, yhi, ti, rad, dy, rt;
  logic [RW-1:0]           ady, trial;
  logic [QW-1:0]           rr, dd, tsq;
  logic                    circ_out;
  logic [CANVAS_WIDTH-1:0] edge_mask;

  assign ax  = EW'(sh_q.ax);
  assign ay  = EW'(sh_q.ay);
  assign bx  = EW'(sh_q.bx);
  assign by  = EW'(sh_q.by);
  assign xlo = (ax > bx) ? bx : ax;
  assign xhi = (ax > bx) ? ax : bx;
  assign ylo = (ay > by) ? by : ay;
  assign yhi = (ay > by) ? ay : by;
  assign ti  = y_q - ay;
  assign rad = $signed({{(EW-RW){1'b0}}, sh_q.radius});
  assign dy  = y_q - ay;
  assign rt  = $signed({{(EW-RW){1'b0}}, root_q});

  // Disc row test and the remaining squared half width.
  assign circ_out = (dy < -rad) || (dy > rad);
  assign ady      = (dy < 0) ? RW'(-dy) : RW'(dy);
  assign rr       = QW'(sh_q.radius) * QW'(sh_q.radius);
  assign dd       = QW'(ady) * QW'(ady);
  assign trial    = root_q | (RW'(1) << bit_q);
  assign tsq      = QW'(trial) * QW'(trial);

  // Coverage of the straight-edged kinds.
  always_comb begin
    edge_mask = '0;
    case (dlsr_pkg::kind_e'(sh_q.kind))
      dlsr_pkg::KIND_RECT: begin
        if (y_q >= ylo && y_q <= yhi) begin
          if (y_q == ylo || y_q == yhi) edge_mask = span(xlo, xhi);
          else edge_mask = span(ax, ax) | span(bx, bx);
        end
      end
      dlsr_pkg::KIND_LINE: begin
        if (ay == by) begin
          if (y_q == ay) edge_mask = span(xlo, xhi);
        end else if (ax == bx) begin
          if (y_q >= ylo && y_q <= yhi) edge_mask = span(ax, ax);
        end
      end
      dlsr_pkg::KIND_TRI: begin
        if (bx > EW'(0) && ti >= EW'(0) && ti < bx) begin
          edge_mask = span(ax - ti, ax - ti) | span(ax + ti, ax + ti);
          if (ti == bx - EW'(1))
            edge_mask = edge_mask | span(ax - bx + EW'(1), ax + bx - EW'(1));
        end
      end
      default: edge_mask = '0;
    endcase
  end

  // Sequencer: evaluate, then for a disc take the root one bit a cycle.
  always_comb begin
    cst_d  = cst_q;
    rest_d = rest_q;
    root_d = root_q;
    bit_d  = bit_q;
    mask_d = mask_q;
    case (cst_q)
      C_IDLE: if (req_i.start) cst_d = C_EVAL;
      C_EVAL: begin
        if (dlsr_pkg::kind_e'(sh_q.kind) == dlsr_pkg::KIND_CIRC && !circ_out) begin
          rest_d = rr - dd;
          root_d = '0;
          bit_d  = 3'(RW - 1);
          cst_d  = C_SQRT;
        end else begin
          mask_d = (dlsr_pkg::kind_e'(sh_q.kind) == dlsr_pkg::KIND_CIRC) ? '0 : edge_mask;
          cst_d  = C_DONE;
        end
      end
      C_SQRT: begin
        if (tsq <= rest_q) root_d = trial;
        if (bit_q == 3'd0) cst_d = C_FIN;
        else bit_d = bit_q - 3'd1;
      end
      C_FIN: begin
        mask_d = span(ax - rt, ax + rt);
        cst_d  = C_DONE;
      end
      C_DONE: cst_d = C_IDLE;
      default: cst_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= C_IDLE;
    end else begin
      cst_q <= cst_d;
    end
  end

  // Working registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cst_q == C_IDLE && req_i.start) begin
      sh_q <= shape_i;
      y_q  <= $signed({{(EW-dlsr_pkg::ROW_W){1'b0}}, req_i.row});
    end
    rest_q <= rest_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    mask_q <= mask_d;
  end

  assign done_o = (cst_q == C_DONE);
  assign mask_o = mask_q;

endmodule

// ===== rtl/display_list_shape_rasterizer_unit.sv =====
// Channel  Modport  Beat carries
// cmd_i    sink     opcode, shape_kind, point_a/b x/y, circle_radius, position
// res_o    source   status, row_number, row_pixels, shapes_held, last
//
// Add, a bad delete and the unused opcode go straight to the response; delete
// moves each entry above the gap one place down. Render visits, per row, each
// shape: a memory read and an evaluation, with a bit-serial root for a disc.
// Reset clears state, shape count and output valid, not the shape memory.
// A result waits in the output register; a stalled result holds the sequencer.
module display_list_shape_rasterizer_unit #(
  parameter int CANVAS_WIDTH  = 50,
  parameter int CANVAS_HEIGHT = 20,
  parameter int MAX_SHAPES    = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlsr_cmd_if.sink   cmd_i,
  dlsr_res_if.source res_o
);

  localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
  localparam int CW = $clog2(MAX_SHAPES + 1);
  localparam int YW = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_RESP   = 8'b00000010,
    S_DRD    = 8'b00000100,
    S_DWR    = 8'b00001000,
    S_RRD    = 8'b00010000,
    S_RSTART = 8'b00100000,
    S_RWAIT  = 8'b01000000,
    S_ROUT   = 8'b10000000
  } st_e;

  st_e                     st_q, st_d;
  logic [CW-1:0]           total_q, total_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [YW-1:0]           row_q, row_d;
  logic [CANVAS_WIDTH-1:0] acc_q, acc_d;
  logic [1:0]              code_q, code_d;

  // Output register.
  logic                    ov_q, ov_d;
  logic [1:0]              o_st_q, o_st_d;
  logic [4:0]              o_row_q, o_row_d;
  logic [CANVAS_WIDTH-1:0] o_pix_q, o_pix_d;
  logic [4:0]              o_held_q, o_held_d;
  logic                    o_last_q, o_last_d;
  logic                    out_free, load;

  // Shape memory ports.
  dlsr_pkg::shape_t        mem [MAX_SHAPES];
  dlsr_pkg::shape_t        rd_q, wd;
  logic                    we, re;
  logic [AW-1:0]           wa, ra;

  dlsr_pkg::cover_req_t    creq;
  logic                    cdone;
  logic [CANVAS_WIDTH-1:0] cmask;

  logic                    accept;
  logic [CW:0]             idx_p1, idx_p2;
  logic [CW:0]             pos_ext;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !ov_q || res_o.ready;
  assign idx_p1   = {1'b0, idx_q} + (CW+1)'(1);
  assign idx_p2   = {1'b0, idx_q} + (CW+1)'(2);
  assign pos_ext  = (CW+1)'(cmd_i.position);

  assign wd = (st_q == S_IDLE) ?
              dlsr_pkg::shape_t'{kind: cmd_i.shape_kind, ax: cmd_i.point_a_x,
                ay: cmd_i.point_a_y, bx: cmd_i.point_b_x, by: cmd_i.point_b_y,
                radius: cmd_i.circle_radius}
              : rd_q;

  // Command sequencer.
  always_comb begin
    st_d     = st_q;
    total_d  = total_q;
    idx_d    = idx_q;
    row_d    = row_q;
    acc_d    = acc_q;
    code_d   = code_q;
    we       = 1'b0;
    re       = 1'b0;
    wa       = total_q[AW-1:0];
    ra       = idx_q[AW-1:0];
    load     = 1'b0;
    o_st_d   = o_st_q;
    o_row_d  = o_row_q;
    o_pix_d  = o_pix_q;
    o_held_d = o_held_q;
    o_last_d = o_last_q;
    creq     = '{start: 1'b0, row: dlsr_pkg::ROW_W'(row_q)};
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          code_d = dlsr_pkg::ST_OK;
          st_d   = S_RESP;
          case (dlsr_pkg::op_e'(cmd_i.opcode))
            dlsr_pkg::OP_ADD: begin
              if (total_q >= CW'(MAX_SHAPES)) begin
                code_d = dlsr_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                total_d = total_q + CW'(1);
              end
            end
            dlsr_pkg::OP_DEL: begin
              if (pos_ext == '0 || pos_ext > (CW+1)'(total_q)) begin
                code_d = dlsr_pkg::ST_BADPOS;
              end else if (pos_ext == (CW+1)'(total_q)) begin
                total_d = total_q - CW'(1);
              end else begin
                idx_d = CW'(pos_ext - (CW+1)'(1));
                st_d  = S_DRD;
              end
            end
            dlsr_pkg::OP_RENDER: begin
              row_d = '0;
              idx_d = '0;
              acc_d = '0;
              st_d  = S_RRD;
            end
            default: st_d = S_RESP;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          load     = 1'b1;
          o_st_d   = code_q;
          o_row_d  = '0;
          o_pix_d  = '0;
          o_held_d = 5'(total_q);
          o_last_d = 1'b1;
          st_d     = S_IDLE;
        end
      end
      // Close the gap: read the entry above, write it one place down.
      S_DRD: begin
        re   = 1'b1;
        ra   = idx_p1[AW-1:0];
        st_d = S_DWR;
      end
      S_DWR: begin
        we = 1'b1;
        wa = idx_q[AW-1:0];
        if (idx_p2 == (CW+1)'(total_q)) begin
          total_d = total_q - CW'(1);
          st_d    = S_RESP;
        end else begin
          idx_d = CW'(idx_p1);
          st_d  = S_DRD;
        end
      end
      // Render: visit each stored shape for the current row.
      S_RRD: begin
        if (idx_q == total_q) begin
          st_d = S_ROUT;
        end else begin
          re   = 1'b1;
          st_d = S_RSTART;
        end
      end
      S_RSTART: begin
        creq.start = 1'b1;
        st_d       = S_RWAIT;
      end
      S_RWAIT: begin
        if (cdone) begin
          acc_d = acc_q | cmask;
          idx_d = CW'(idx_p1);
          st_d  = S_RRD;
        end
      end
      S_ROUT: begin
        if (out_free) begin
          load     = 1'b1;
          o_st_d   = dlsr_pkg::ST_OK;
          o_row_d  = 5'(row_q);
          o_pix_d  = acc_q;
          o_held_d = 5'(total_q);
          o_last_d = (row_q == YW'(CANVAS_HEIGHT - 1));
          idx_d    = '0;
          acc_d    = '0;
          if (row_q == YW'(CANVAS_HEIGHT - 1)) begin
            st_d = S_IDLE;
          end else begin
            row_d = row_q + YW'(1);
            st_d  = S_RRD;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) ov_d = 1'b1;
    else if (res_o.ready) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      total_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      total_q <= total_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    row_q    <= row_d;
    acc_q    <= acc_d;
    code_q   <= code_d;
    o_st_q   <= o_st_d;
    o_row_q  <= o_row_d;
    o_pix_q  <= o_pix_d;
    o_held_q <= o_held_d;
    o_last_q <= o_last_d;
  end

  // Shape memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  dlsr_cover #(
    .CANVAS_WIDTH (CANVAS_WIDTH)
  ) u_cover (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (creq),
    .shape_i (rd_q),
    .done_o  (cdone),
    .mask_o  (cmask)
  );

  assign cmd_i.ready       = (st_q == S_IDLE);
  assign res_o.valid       = ov_q;
  assign res_o.status      = o_st_q;
  assign res_o.row_number  = o_row_q;
  assign res_o.row_pixels  = o_pix_q;
  assign res_o.shapes_held = o_held_q;
  assign res_o.last        = o_last_q;

  // The list never grows past its capacity.
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_SHAPES))
    else $error("shape count above capacity");

  // A read and a write never hit the same entry in one cycle.
  a_no_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (wa != ra))
    else $error("shape memory read and write collide");

  // A marked row result carries either row zero or the bottom row.
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && o_last_q) |-> (o_row_q == 5'd0 || o_row_q == 5'(CANVAS_HEIGHT - 1)))
    else $error("last beat on an inner row");

  // The coverage unit answers only while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (st_q == S_RWAIT))
    else $error("coverage result outside of a wait");

endmodule
